@@ rtl/slfc_pkg.sv @@
// Shared types and constants for the serial link frame controller.
package slfc_pkg;

    typedef enum logic [2:0] {
        OP_RX_BYTE = 3'd0,
        OP_HELLO   = 3'd1,
        OP_SET_MODE = 3'd2,
        OP_SET_TX  = 3'd3,
        OP_SET_CD  = 3'd4
    } op_e_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_BAD_LEN  = 2'd2,
        EV_BAD_TYPE = 2'd3
    } rx_event_t;

    localparam logic [7:0] FRAME_START  = 8'hF0;
    localparam logic [7:0] CMD_HELLO    = 8'h00;
    localparam logic [7:0] CMD_SET_MODE = 8'h01;
    localparam logic [7:0] CMD_SET_TX   = 8'h02;
    localparam logic [7:0] CMD_SET_CD   = 8'h03;
    localparam logic [7:0] TYPE_READ    = 8'h11;
    localparam logic [7:0] TYPE_STATUS  = 8'h50;
    localparam logic [7:0] LENGTH_LIMIT = 8'd250;
    localparam logic [7:0] LEN_HELLO    = 8'd3;
    localparam logic [7:0] LEN_SET      = 8'd4;
    localparam logic [7:0] FOURTH_POS   = 8'd3;

    typedef struct packed {
        logic            is_rx;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
        rx_event_t       rx_event;
        logic            lockout;
    } desc_t;

endpackage

@@ rtl/slfc_proc.sv @@
// Input register, deframer and command state, producing at most one result descriptor per request.
module slfc_proc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_op,
    input  logic [7:0]           s_rx_byte,
    input  logic [7:0]           s_mode_value,
    input  logic                 s_flag_value,
    input  logic                 take,
    output logic                 desc_valid,
    output slfc_pkg::desc_t      desc
);

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_TYPE   = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    logic                  in_valid_reg;
    slfc_pkg::op_e_t       op_reg;
    logic [7:0]            rx_reg;
    logic [7:0]            mode_in_reg;
    logic                  flag_in_reg;

    phase_t                phase_reg, phase_next;
    logic [7:0]            len_reg, len_next;
    logic [7:0]            pos_reg, pos_next;
    logic                  status_reg, status_next;
    logic                  fourth_reg, fourth_next;
    logic                  lockout_reg, lockout_next;
    logic [7:0]            mode_reg, mode_next;
    logic                  tx_on_reg, tx_on_next;
    logic                  cd_on_reg, cd_on_next;

    logic                  fire;
    logic [7:0]            pos_inc;
    logic                  finish;

    assign s_ready = !in_valid_reg || take;
    assign fire    = in_valid_reg && take;
    assign pos_inc = pos_reg + 8'd1;

    always_comb begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        fourth_next  = fourth_reg;
        lockout_next = lockout_reg;
        mode_next    = mode_reg;
        tx_on_next   = tx_on_reg;
        cd_on_next   = cd_on_reg;
        finish       = 1'b0;
        desc_valid   = 1'b0;
        desc         = '0;
        desc.bytes[0] = slfc_pkg::FRAME_START;
        desc.bytes[1] = slfc_pkg::LEN_SET;
        unique case (op_reg)
            slfc_pkg::OP_RX_BYTE: begin
                desc_valid    = in_valid_reg;
                desc.is_rx    = 1'b1;
                desc.last_idx = 2'd0;
                desc.bytes    = '0;
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (rx_reg == slfc_pkg::FRAME_START) begin
                            phase_next = PH_LENGTH;
                            pos_next   = 8'd1;
                        end
                    end
                    PH_LENGTH: begin
                        if (rx_reg >= slfc_pkg::LENGTH_LIMIT) begin
                            phase_next    = PH_HUNT;
                            pos_next      = 8'd0;
                            desc.rx_event = slfc_pkg::EV_BAD_LEN;
                        end else begin
                            len_next   = rx_reg;
                            phase_next = PH_TYPE;
                            pos_next   = 8'd2;
                        end
                    end
                    PH_TYPE: begin
                        if (rx_reg != slfc_pkg::TYPE_STATUS &&
                            rx_reg != slfc_pkg::TYPE_READ) begin
                            phase_next    = PH_HUNT;
                            pos_next      = 8'd0;
                            desc.rx_event = slfc_pkg::EV_BAD_TYPE;
                        end else begin
                            status_next = (rx_reg == slfc_pkg::TYPE_STATUS);
                            pos_next    = slfc_pkg::FOURTH_POS;
                            if (slfc_pkg::FOURTH_POS >= len_reg) begin
                                finish = 1'b1;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        if (pos_reg == slfc_pkg::FOURTH_POS) begin
                            fourth_next = rx_reg[0];
                        end
                        pos_next = pos_inc;
                        if (pos_inc >= len_reg) begin
                            finish = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
                if (finish) begin
                    if (status_next) begin
                        lockout_next = fourth_next;
                    end
                    phase_next    = PH_HUNT;
                    pos_next      = 8'd0;
                    desc.rx_event = slfc_pkg::EV_COMPLETE;
                end
            end
            slfc_pkg::OP_HELLO: begin
                desc_valid    = in_valid_reg;
                desc.last_idx = 2'd2;
                desc.bytes[1] = slfc_pkg::LEN_HELLO;
                desc.bytes[2] = slfc_pkg::CMD_HELLO;
            end
            slfc_pkg::OP_SET_MODE: begin
                desc_valid    = in_valid_reg && (mode_in_reg != mode_reg);
                mode_next     = mode_in_reg;
                desc.last_idx = 2'd3;
                desc.bytes[2] = slfc_pkg::CMD_SET_MODE;
                desc.bytes[3] = mode_in_reg;
            end
            slfc_pkg::OP_SET_TX: begin
                desc_valid    = in_valid_reg && (flag_in_reg != tx_on_reg);
                tx_on_next    = flag_in_reg;
                desc.last_idx = 2'd3;
                desc.bytes[2] = slfc_pkg::CMD_SET_TX;
                desc.bytes[3] = {7'd0, flag_in_reg};
            end
            slfc_pkg::OP_SET_CD: begin
                desc_valid    = in_valid_reg && (flag_in_reg != cd_on_reg);
                cd_on_next    = flag_in_reg;
                desc.last_idx = 2'd3;
                desc.bytes[2] = slfc_pkg::CMD_SET_CD;
                desc.bytes[3] = {7'd0, flag_in_reg};
            end
            default: begin
                desc_valid = 1'b0;
            end
        endcase
        desc.lockout = lockout_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HUNT;
            len_reg      <= 8'd0;
            pos_reg      <= 8'd0;
            status_reg   <= 1'b0;
            fourth_reg   <= 1'b0;
            lockout_reg  <= 1'b0;
            mode_reg     <= 8'd0;
            tx_on_reg    <= 1'b0;
            cd_on_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                phase_reg   <= phase_next;
                len_reg     <= len_next;
                pos_reg     <= pos_next;
                status_reg  <= status_next;
                fourth_reg  <= fourth_next;
                lockout_reg <= lockout_next;
                mode_reg    <= mode_next;
                tx_on_reg   <= tx_on_next;
                cd_on_reg   <= cd_on_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= slfc_pkg::op_e_t'(s_op);
            rx_reg      <= s_rx_byte;
            mode_in_reg <= s_mode_value;
            flag_in_reg <= s_flag_value;
        end
    end

`ifndef SYNTHESIS
    a_hunt_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HUNT |-> pos_reg == 8'd0)
        else $error("position not cleared while hunting");
    a_body_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> pos_reg >= slfc_pkg::FOURTH_POS && pos_reg < len_reg)
        else $error("body position out of frame");
    a_lockout_only_on_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && op_reg != slfc_pkg::OP_RX_BYTE |=> $stable(lockout_reg))
        else $error("lockout changed by a command");
`endif

endmodule

@@ rtl/slfc_emit.sv @@
// Result register that plays out a descriptor one result per cycle while m_ready is high.
module slfc_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            desc_valid,
    input  slfc_pkg::desc_t desc,
    output logic            take,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_tx_valid,
    output logic [7:0]      m_tx_byte,
    output logic            m_last,
    output logic [1:0]      m_rx_event,
    output logic            m_lock_state
);

    logic            busy_reg;
    logic [1:0]      idx_reg;
    slfc_pkg::desc_t desc_reg;
    logic            at_last;

    assign at_last      = (idx_reg == desc_reg.last_idx);
    assign take         = !busy_reg || (m_ready && at_last);
    assign m_valid      = busy_reg;
    assign m_tx_valid   = !desc_reg.is_rx;
    assign m_tx_byte    = desc_reg.bytes[idx_reg];
    assign m_last       = at_last;
    assign m_rx_event   = desc_reg.rx_event;
    assign m_lock_state = desc_reg.lockout;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (take) begin
            busy_reg <= desc_valid;
            idx_reg  <= 2'd0;
        end else if (m_ready) begin
            idx_reg  <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && desc_valid) begin
            desc_reg <= desc;
        end
    end

`ifndef SYNTHESIS
    a_rx_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_last && m_tx_byte == 8'd0)
        else $error("received-byte result not single");
    a_event_no_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rx_event != slfc_pkg::EV_NONE |-> !m_tx_valid)
        else $error("event on a transmit result");
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid && idx_reg == 2'd0 |-> m_tx_byte == slfc_pkg::FRAME_START)
        else $error("frame does not open with start byte");
`endif

endmodule

@@ rtl/serial_link_frame_controller_core.sv @@
// Top level of the serial link frame controller.
// Input channel (s_*): one request per item. s_op selects a received byte
// (deframed), hello, set mode, set transmit or set carrier. Result channel
// (m_*): each request yields zero to four results; m_last marks the final
// one of a request. A received byte yields one result with m_tx_valid low,
// carrying m_rx_event and the current m_lock_state. Commands yield their frame
// bytes with m_tx_valid high; an unchanged set and op codes 5 to 7 yield none.
// A request accepted at the input is held in the input register and then
// loaded into the result register, which shows its results. Throughput: one
// request per cycle for received bytes and no-result requests, with command
// bytes played out one per cycle, while m_ready stays high. A request is taken
// in while the previous one is still playing out its last result.
// Reset (aresetn low at a clock edge) returns the deframer to hunting for a
// start byte and clears lockout, mode, transmit and carrier state; no result
// is pending afterwards. When m_ready is low the current result holds, the
// input register fills, and then s_ready drops until results drain.
module serial_link_frame_controller_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [7:0] s_rx_byte,
    input  logic [7:0] s_mode_value,
    input  logic       s_flag_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic       m_last,
    output logic [1:0] m_rx_event,
    output logic       m_lock_state
);

    logic            take;
    logic            desc_valid;
    slfc_pkg::desc_t desc;

    slfc_proc u_proc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_rx_byte    (s_rx_byte),
        .s_mode_value (s_mode_value),
        .s_flag_value (s_flag_value),
        .take         (take),
        .desc_valid   (desc_valid),
        .desc         (desc)
    );

    slfc_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .desc_valid   (desc_valid),
        .desc         (desc),
        .take         (take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_valid   (m_tx_valid),
        .m_tx_byte    (m_tx_byte),
        .m_last       (m_last),
        .m_rx_event   (m_rx_event),
        .m_lock_state (m_lock_state)
    );

endmodule

@@ test/testbench.sv @@
// Testbench for serial_link_frame_controller_core: directed table plus random framed traffic.
`timescale 1ns / 1ps

module testbench;
    import slfc_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_TYPE = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    localparam int RANDOM_REQUESTS = 256;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 12;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        rx_event_t  rx_event;
        logic       lockout;
    } link_result_t;

    typedef struct {
        logic [2:0]      op;
        logic [7:0]      rx;
        logic [7:0]      mode;
        logic            flag;
        bit              typed;
        int              n;
        logic [3:0][7:0] bytes;
        rx_event_t       ev;
        logic            lock;
    } step_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_op;
    logic [7:0] s_rx_byte;
    logic [7:0] s_mode_value;
    logic       s_flag_value;
    logic       m_valid;
    logic       m_ready;
    logic       m_tx_valid;
    logic [7:0] m_tx_byte;
    logic       m_last;
    logic [1:0] m_rx_event;
    logic       m_lock_state;

    logic [1:0] pr_phase;
    logic [7:0] pr_len;
    logic [7:0] pr_pos;
    logic       pr_is_status;
    logic       pr_fourth;
    logic       pr_lock;
    logic [7:0] pr_mode;
    logic       pr_tx_on;
    logic       pr_cd_on;

    link_result_t expected_results[$];
    step_row_t    directed_steps[$];
    int           mismatch_count;
    int           quiet_cycles;
    bit           idle_on;

    serial_link_frame_controller_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_rx_byte    (s_rx_byte),
        .s_mode_value (s_mode_value),
        .s_flag_value (s_flag_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_valid   (m_tx_valid),
        .m_tx_byte    (m_tx_byte),
        .m_last       (m_last),
        .m_rx_event   (m_rx_event),
        .m_lock_state (m_lock_state)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic void link_predict(input logic [2:0] op, input logic [7:0] rxb,
                                         input logic [7:0] mode, input logic flag,
                                         output link_result_t res[$]);
        logic [7:0]   frame [4];
        int           n;
        int           k;
        rx_event_t    ev;
        link_result_t r;
        res = {};
        n = 0;
        ev = EV_NONE;
        frame[0] = FRAME_START;
        frame[1] = LEN_SET;
        frame[2] = CMD_HELLO;
        frame[3] = 8'h00;
        case (op)
            OP_RX_BYTE: begin
                case (pr_phase)
                    PH_HUNT: begin
                        if (rxb == FRAME_START) begin
                            pr_phase = PH_LEN;
                            pr_pos = 8'd1;
                        end
                    end
                    PH_LEN: begin
                        if (rxb >= LENGTH_LIMIT) begin
                            pr_phase = PH_HUNT;
                            pr_pos = 8'd0;
                            ev = EV_BAD_LEN;
                        end else begin
                            pr_len = rxb;
                            pr_phase = PH_TYPE;
                            pr_pos = 8'd2;
                        end
                    end
                    PH_TYPE: begin
                        if (rxb != TYPE_STATUS && rxb != TYPE_READ) begin
                            pr_phase = PH_HUNT;
                            pr_pos = 8'd0;
                            ev = EV_BAD_TYPE;
                        end else begin
                            pr_is_status = (rxb == TYPE_STATUS);
                            pr_pos = FOURTH_POS;
                            pr_phase = PH_BODY;
                        end
                    end
                    default: begin
                        if (pr_pos == FOURTH_POS) pr_fourth = rxb[0];
                        pr_pos = pr_pos + 8'd1;
                    end
                endcase
                // finish on the type byte itself or on the last body byte
                if (pr_phase == PH_BODY && pr_pos >= pr_len
                    && !(ev == EV_BAD_TYPE)) begin
                    if (pr_is_status) pr_lock = pr_fourth;
                    pr_phase = PH_HUNT;
                    pr_pos = 8'd0;
                    ev = EV_COMPLETE;
                end
                r.tx_valid = 1'b0;
                r.tx_byte = 8'h00;
                r.last = 1'b1;
                r.rx_event = ev;
                r.lockout = pr_lock;
                res.push_back(r);
            end
            OP_HELLO: begin
                frame[1] = LEN_HELLO;
                n = 3;
            end
            OP_SET_MODE: begin
                if (mode != pr_mode) begin
                    pr_mode = mode;
                    frame[2] = CMD_SET_MODE;
                    frame[3] = mode;
                    n = 4;
                end
            end
            OP_SET_TX: begin
                if (flag != pr_tx_on) begin
                    pr_tx_on = flag;
                    frame[2] = CMD_SET_TX;
                    frame[3] = {7'd0, flag};
                    n = 4;
                end
            end
            OP_SET_CD: begin
                if (flag != pr_cd_on) begin
                    pr_cd_on = flag;
                    frame[2] = CMD_SET_CD;
                    frame[3] = {7'd0, flag};
                    n = 4;
                end
            end
            default: ;
        endcase
        for (k = 0; k < n; k++) begin
            r.tx_valid = 1'b1;
            r.tx_byte = frame[k];
            r.last = (k == n - 1);
            r.rx_event = EV_NONE;
            r.lockout = pr_lock;
            res.push_back(r);
        end
    endfunction

    function automatic step_row_t make_step(input logic [2:0] op, input logic [7:0] rx,
                                            input logic [7:0] mode, input logic flag);
        step_row_t st;
        st.op = op;
        st.rx = rx;
        st.mode = mode;
        st.flag = flag;
        st.typed = 1'b0;
        st.n = 0;
        st.bytes = '0;
        st.ev = EV_NONE;
        st.lock = 1'b0;
        return st;
    endfunction

    task automatic add_step(input logic [2:0] op, input logic [7:0] rx, input logic [7:0] mode,
                            input logic flag, input bit typed, input int n,
                            input logic [31:0] bytes, input rx_event_t ev, input logic lock);
        step_row_t st;
        st = make_step(op, rx, mode, flag);
        st.typed = typed;
        st.n = n;
        st.bytes = bytes;
        st.ev = ev;
        st.lock = lock;
        directed_steps.push_back(st);
    endtask

    task automatic issue_request(input step_row_t st);
        link_result_t got[$];
        link_result_t r;
        int           k;
        @(negedge aclk);
        while (idle_on && $urandom_range(0, 99) < 28) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op = st.op;
        s_rx_byte = st.rx;
        s_mode_value = st.mode;
        s_flag_value = st.flag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        link_predict(st.op, st.rx, st.mode, st.flag, got);
        if (st.typed) begin
            for (k = 0; k < st.n; k++) begin
                r.tx_valid = (st.op != OP_RX_BYTE);
                r.tx_byte = r.tx_valid ? st.bytes[3 - k] : 8'h00;
                r.last = (k == st.n - 1);
                r.rx_event = st.ev;
                r.lockout = st.lock;
                expected_results.push_back(r);
            end
        end else begin
            foreach (got[j]) expected_results.push_back(got[j]);
        end
    endtask

    task automatic send_rx(input logic [7:0] b);
        issue_request(make_step(OP_RX_BYTE, b, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))));
    endtask

    task automatic send_cmd(input logic [2:0] op, input logic [7:0] mode, input logic flag);
        issue_request(make_step(op, 8'($urandom_range(0, 255)), mode, flag));
    endtask

    function automatic void compare_field(input string name, input int expd, input int got);
        if (expd != got) begin
            $error("%s: expected %0d, got %0d", name, expd, got);
            mismatch_count++;
        end
    endfunction

    always @(negedge aclk) begin
        if (aresetn) m_ready = idle_on ? ($urandom_range(0, 99) >= 28) : 1'b1;
    end

    always @(posedge aclk) begin
        link_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: tx_valid %0d tx_byte %0d", m_tx_valid, m_tx_byte);
                mismatch_count++;
            end else begin
                e = expected_results.pop_front();
                compare_field("tx_valid", e.tx_valid, m_tx_valid);
                compare_field("tx_byte", e.tx_byte, m_tx_byte);
                compare_field("last", e.last, m_last);
                compare_field("rx_event", e.rx_event, m_rx_event);
                compare_field("lock_state", e.lockout, m_lock_state);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        int         sent;
        int         pick;
        int         body;
        bit         paused;
        logic [7:0] len;
        logic [7:0] kind;
        logic [7:0] mode;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_RX_BYTE;
        s_rx_byte = 8'h00;
        s_mode_value = 8'h00;
        s_flag_value = 1'b0;
        m_ready = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        idle_on = 1'b1;
        pr_phase = PH_HUNT;
        pr_len = 8'd0;
        pr_pos = 8'd0;
        pr_is_status = 1'b0;
        pr_fourth = 1'b0;
        pr_lock = 1'b0;
        pr_mode = 8'd0;
        pr_tx_on = 1'b0;
        pr_cd_on = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // commands from reset state
        add_step(OP_SET_MODE, 8'hFF, 8'h00, 1'b1, 1, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_SET_MODE, 8'h00, 8'hFF, 1'b0, 1, 4,
                 {FRAME_START, LEN_SET, CMD_SET_MODE, 8'hFF}, EV_NONE, 1'b0);
        add_step(OP_SET_TX, 8'h00, 8'h00, 1'b1, 1, 4,
                 {FRAME_START, LEN_SET, CMD_SET_TX, 8'h01}, EV_NONE, 1'b0);
        add_step(OP_SET_CD, 8'hFF, 8'hFF, 1'b1, 1, 4,
                 {FRAME_START, LEN_SET, CMD_SET_CD, 8'h01}, EV_NONE, 1'b0);
        add_step(OP_HELLO, 8'hFF, 8'h00, 1'b0, 1, 3,
                 {FRAME_START, LEN_HELLO, CMD_HELLO, 8'h00}, EV_NONE, 1'b0);
        add_step(OP_UNUSED_HI, 8'hFF, 8'hFF, 1'b1, 1, 0, 32'h0, EV_NONE, 1'b0);
        // hunting, bad length, bad type
        add_step(OP_RX_BYTE, 8'h00, 8'h00, 1'b0, 1, 1, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, FRAME_START, 8'h00, 1'b0, 1, 1, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'hFF, 8'h00, 1'b0, 1, 1, 32'h0, EV_BAD_LEN, 1'b0);
        add_step(OP_RX_BYTE, FRAME_START, 8'h00, 1'b0, 1, 1, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, LENGTH_LIMIT, 8'h00, 1'b0, 1, 1, 32'h0, EV_BAD_LEN, 1'b0);
        add_step(OP_RX_BYTE, FRAME_START, 8'h00, 1'b0, 1, 1, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'd5, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'h12, 8'h00, 1'b0, 1, 1, 32'h0, EV_BAD_TYPE, 1'b0);
        // status frame that sets lockout
        add_step(OP_RX_BYTE, FRAME_START, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'd5, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, TYPE_STATUS, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'h01, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'hFF, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        // read frame stores the fourth byte without touching lockout
        add_step(OP_RX_BYTE, FRAME_START, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'd4, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, TYPE_READ, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'hFE, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        // short status frame takes the stored bit
        add_step(OP_RX_BYTE, FRAME_START, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, 8'd3, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);
        add_step(OP_RX_BYTE, TYPE_STATUS, 8'h00, 1'b0, 0, 0, 32'h0, EV_NONE, 1'b0);

        foreach (directed_steps[i]) issue_request(directed_steps[i]);

        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_REQUESTS) begin
            idle_on = !(sent >= 100 && sent < 160);
            if (!paused && sent >= 200) begin
                // hold off until every result has drained
                @(negedge aclk);
                s_valid = 1'b0;
                while (expected_results.size() != 0) @(negedge aclk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45 || pick >= 85) begin
                len = 8'($urandom_range(0, 8));
                pick = (pick >= 85) ? 1 : 0;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8: kind = TYPE_STATUS;
                    9, 10, 11, 12, 13, 14, 15, 16: kind = TYPE_READ;
                    default: kind = 8'($urandom_range(0, 255));
                endcase
                body = ((kind == TYPE_STATUS || kind == TYPE_READ) && len > 3) ? len - 3 : 0;
                if (pick == 1) body = $urandom_range(0, body);
                send_rx(FRAME_START);
                send_rx(len);
                send_rx(kind);
                for (int k = 0; k < body; k++) send_rx(8'($urandom_range(0, 255)));
                sent += 3 + body;
            end else if (pick < 62) begin
                mode = ($urandom_range(0, 2) == 0) ? pr_mode : 8'($urandom_range(0, 255));
                send_cmd(3'($urandom_range(OP_HELLO, OP_SET_CD)), mode,
                         1'($urandom_range(0, 1)));
                sent++;
            end else if (pick < 72) begin
                send_rx(8'($urandom_range(0, 255)));
                sent++;
            end else if (pick < 80) begin
                send_rx(FRAME_START);
                send_rx(8'($urandom_range(LENGTH_LIMIT, 255)));
                sent += 2;
            end else begin
                send_cmd(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/slfc_pkg.sv
rtl/slfc_proc.sv
rtl/slfc_emit.sv
rtl/serial_link_frame_controller_core.sv
test/testbench.sv
